@@ sv/bplc_pkg.sv @@
// Shared types and constants for the button press LED controller.
`timescale 1ns / 1ps
`default_nettype none

package bplc_pkg;

  typedef enum logic [1:0] {
    UNPRESSED   = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2
  } press_class_t;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_ON   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_OFF  = 8'd3;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_HOLD_RESET  = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] BLINK_ON_RESET   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] BLINK_OFF_RESET  = 16'd1000;

  typedef logic signed [1:0] press_change_t;
  localparam press_change_t CHANGE_NONE = 2'sb00;
  localparam press_change_t CHANGE_RISE = 2'sb01;
  localparam press_change_t CHANGE_FALL = 2'sb11;

endpackage

`default_nettype wire

@@ sv/button_press_led_controller.sv @@
// Top level: tick-driven debounced short/long press classifier with LED toggle and blink.
//
// Each input transaction on in_valid/in_ready is one 1 ms tick carrying the raw
// button pin (button_level, 0 = pressed). The tick updates the press
// classifier, the LED and the blinker, and produces exactly one result
// transaction on out_valid/out_ready: led_on, press_class, press_change and
// blinking, all as seen after that tick.
// The result is in the output register on the clock after the tick is accepted.
// Throughput is one tick per cycle while the receiver drains each result; all state is
// updated by a single short compare-and-update step at the acceptance edge.
// The output register decouples the sides: a new tick is taken whenever the
// output register is empty or is being drained in the same cycle, so a stalled
// receiver holds off only further ticks, never an undelivered result.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; indexes 0..3 select debounce, long press, blink on and blink off
// times, other indexes are ignored. Write it only while the block is idle.
// Synchronous reset restores the default times (50, 3000, 500, 1000 ticks),
// clears all classifier, LED and blink state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module button_press_led_controller #(
  parameter int TIMER_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   button_level,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  led_on,
  output logic [1:0]                            press_class,
  output logic signed [1:0]                     press_change,
  output logic                                  blinking,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [bplc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [bplc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CMP_W = (TIMER_BITS > bplc_pkg::CFG_DATA_W) ? TIMER_BITS
                                                             : bplc_pkg::CFG_DATA_W;

  logic [bplc_pkg::CFG_DATA_W-1:0] debounce_ticks;
  logic [bplc_pkg::CFG_DATA_W-1:0] long_hold_ticks;
  logic [bplc_pkg::CFG_DATA_W-1:0] blink_on_ticks;
  logic [bplc_pkg::CFG_DATA_W-1:0] blink_off_ticks;

  bplc_pkg::press_class_t press_state, press_state_next;
  logic                   last_pressed, last_pressed_next;
  logic [TIMER_BITS-1:0]  press_elapsed, press_elapsed_next;
  logic                   led_level, led_level_next;
  logic                   blink_enabled, blink_enabled_next;
  logic [TIMER_BITS-1:0]  blink_elapsed, blink_elapsed_next;

  logic                    pressed;
  logic                    accept;
  logic [TIMER_BITS-1:0]   press_inc;
  logic [TIMER_BITS-1:0]   blink_inc;
  logic [CMP_W-1:0]        press_cmp;
  logic [CMP_W-1:0]        blink_cmp;
  logic                    led_blinked;
  bplc_pkg::press_change_t change;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign pressed   = !button_level;

  // Elapsed counters advance first and saturate at all ones.
  assign press_inc = (press_elapsed == '1) ? press_elapsed : press_elapsed + 1'b1;
  assign blink_inc = (blink_elapsed == '1) ? blink_elapsed : blink_elapsed + 1'b1;
  assign press_cmp = CMP_W'(press_inc);
  assign blink_cmp = CMP_W'(blink_inc);

  // Press classifier next state.
  always_comb begin
    press_state_next   = press_state;
    last_pressed_next  = last_pressed;
    press_elapsed_next = press_inc;
    case (press_state)
      bplc_pkg::CLASS_SHORT: begin
        if (!pressed) begin
          press_state_next   = bplc_pkg::UNPRESSED;
          press_elapsed_next = '0;
        end else if (press_cmp > CMP_W'(long_hold_ticks)) begin
          press_state_next = bplc_pkg::CLASS_LONG;
        end
      end
      bplc_pkg::CLASS_LONG: begin
        if (!pressed) begin
          press_state_next   = bplc_pkg::UNPRESSED;
          press_elapsed_next = '0;
        end
      end
      default: begin
        press_state_next = bplc_pkg::UNPRESSED;
        if (pressed != last_pressed) begin
          press_elapsed_next = '0;
          last_pressed_next  = pressed;
        end else if (pressed && press_cmp > CMP_W'(debounce_ticks)) begin
          press_state_next = bplc_pkg::CLASS_SHORT;
        end
      end
    endcase
  end

  // Blinker, change report and the LED actions of a rising class.
  always_comb begin
    led_blinked        = led_level;
    blink_elapsed_next = blink_inc;
    if (blink_enabled) begin
      if (!led_level && blink_cmp >= CMP_W'(blink_off_ticks)) begin
        led_blinked        = 1'b1;
        blink_elapsed_next = '0;
      end else if (led_level && blink_cmp >= CMP_W'(blink_on_ticks)) begin
        led_blinked        = 1'b0;
        blink_elapsed_next = '0;
      end
    end

    if (press_state_next > press_state) begin
      change = bplc_pkg::CHANGE_RISE;
    end else if (press_state_next < press_state) begin
      change = bplc_pkg::CHANGE_FALL;
    end else begin
      change = bplc_pkg::CHANGE_NONE;
    end

    led_level_next     = led_blinked;
    blink_enabled_next = blink_enabled;
    if (change == bplc_pkg::CHANGE_RISE) begin
      if (press_state_next == bplc_pkg::CLASS_LONG) begin
        blink_enabled_next = !blink_enabled;
        led_level_next     = 1'b0;
      end else if (press_state_next == bplc_pkg::CLASS_SHORT) begin
        led_level_next     = !led_level;
        blink_enabled_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bplc_pkg::DEBOUNCE_RESET;
      long_hold_ticks  <= bplc_pkg::LONG_HOLD_RESET;
      blink_on_ticks   <= bplc_pkg::BLINK_ON_RESET;
      blink_off_ticks  <= bplc_pkg::BLINK_OFF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bplc_pkg::REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        bplc_pkg::REG_LONG_HOLD:  long_hold_ticks  <= cfg_data;
        bplc_pkg::REG_BLINK_ON:   blink_on_ticks   <= cfg_data;
        bplc_pkg::REG_BLINK_OFF:  blink_off_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_state   <= bplc_pkg::UNPRESSED;
      last_pressed  <= 1'b0;
      press_elapsed <= '0;
      led_level     <= 1'b0;
      blink_enabled <= 1'b0;
      blink_elapsed <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        press_state   <= press_state_next;
        last_pressed  <= last_pressed_next;
        press_elapsed <= press_elapsed_next;
        led_level     <= led_level_next;
        blink_enabled <= blink_enabled_next;
        blink_elapsed <= blink_elapsed_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      led_on       <= led_level_next;
      press_class  <= press_state_next;
      press_change <= change;
      blinking     <= blink_enabled_next;
    end
  end

  // A fall always lands in the unpressed class.
  a_fall_to_unpressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_change == bplc_pkg::CHANGE_FALL |-> press_class == bplc_pkg::UNPRESSED)
    else $error("press class fell to a pressed class");

  // A rise to long press turns the LED off.
  a_long_led_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_change == bplc_pkg::CHANGE_RISE && press_class == bplc_pkg::CLASS_LONG
    |-> !led_on)
    else $error("LED on after rise to long press");

  // A rise to short press stops blinking.
  a_short_stops_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_change == bplc_pkg::CHANGE_RISE && press_class == bplc_pkg::CLASS_SHORT
    |-> !blinking)
    else $error("blinking still on after short press");

  // An accepted tick always leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire
